### src/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants for the sprite run-length run decoder.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int RUN_W       = 20;
    localparam int BYTE_W      = 8;
    localparam int PIX_OFF_W   = 24;
    localparam int SUM_W       = ((OFFSET_BITS > RUN_W) ? OFFSET_BITS : RUN_W) + 1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // header run types, bits 7..6
    localparam logic [1:0] RT_LITERAL = 2'b00;
    localparam logic [1:0] RT_STOP    = 2'b01;
    localparam logic [1:0] RT_FILL    = 2'b10;
    localparam logic [1:0] RT_SKIP    = 2'b11;

    // header length codes, bits 5..4
    localparam logic [1:0] LC_NIBBLE = 2'd0;
    localparam logic [1:0] LC_ONE    = 2'd1;
    localparam logic [1:0] LC_TWO    = 2'd2;
    localparam logic [1:0] LC_NONE   = 2'd3;

    typedef enum logic [2:0] {
        KIND_FILL    = 3'd0,
        KIND_LITERAL = 3'd1,
        KIND_SKIP    = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_FRAME   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COLOR   = 3'd1,
        PH_LEN1    = 3'd2,
        PH_LEN2    = 3'd3,
        PH_LITERAL = 3'd4,
        PH_STOPPED = 3'd5
    } phase_t;

    // one decoded command, front to back
    typedef struct packed {
        kind_t             kind;
        logic [RUN_W-1:0]  run_count;
        logic [BYTE_W-1:0] value;
        logic              frame_end;
        logic              truncated;
    } cmd_t;

endpackage

### src/srd_front.sv
// ----------------------------------------------------------------------------
// srd_front
// Header parser: walks the compressed byte stream and emits run commands.
// ----------------------------------------------------------------------------
module srd_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [srd_pkg::BYTE_W-1:0]   in_data,
    input  logic                         in_last,
    output logic                         push,
    output srd_pkg::cmd_t                push_cmd
);
    import srd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [1:0]        run_type_reg, run_type_next;
    logic [1:0]        len_code_reg, len_code_next;
    logic [RUN_W-1:0]  run_len_reg, run_len_next;
    logic [RUN_W-1:0]  lit_left_reg, lit_left_next;
    logic [BYTE_W-1:0] color_reg, color_next;

    logic              accept;
    logic [1:0]        hdr_type;
    logic [1:0]        hdr_code;
    logic [RUN_W-1:0]  hdr_len;
    logic [RUN_W-1:0]  len_shift;
    logic              code_ext;

    // finish-command inputs
    logic              fin;
    logic [1:0]        fin_type;
    logic [RUN_W-1:0]  fin_len;
    logic [BYTE_W-1:0] fin_color;
    logic              emit;
    kind_t             emit_kind;
    logic [RUN_W-1:0]  emit_count;
    logic [BYTE_W-1:0] emit_value;
    logic              trunc;

    assign accept    = in_valid && in_ready;
    assign hdr_type  = in_data[7:6];
    assign hdr_code  = in_data[5:4];
    assign hdr_len   = (hdr_code == LC_NONE) ? '0 : RUN_W'(in_data[3:0]);
    assign len_shift = {run_len_reg[RUN_W-BYTE_W-1:0], in_data};
    assign code_ext  = (len_code_reg == LC_ONE) || (len_code_reg == LC_TWO);

    // which step completes a command, and with what
    always_comb begin
        fin       = 1'b0;
        fin_type  = run_type_reg;
        fin_len   = run_len_reg;
        fin_color = color_reg;
        case (phase_reg)
            PH_COLOR: begin
                fin       = !code_ext;
                fin_color = in_data;
            end
            PH_LEN1: begin
                fin     = (len_code_reg != LC_TWO);
                fin_len = len_shift;
            end
            PH_LEN2: begin
                fin     = 1'b1;
                fin_len = len_shift;
            end
            PH_LITERAL, PH_STOPPED: begin
                fin = 1'b0;
            end
            default: begin
                fin      = (hdr_type == RT_LITERAL || hdr_type == RT_SKIP) &&
                           !(hdr_code == LC_ONE || hdr_code == LC_TWO);
                fin_type = hdr_type;
                fin_len  = hdr_len;
            end
        endcase
    end

    // next state
    always_comb begin
        phase_next    = phase_reg;
        run_type_next = run_type_reg;
        len_code_next = len_code_reg;
        run_len_next  = run_len_reg;
        lit_left_next = lit_left_reg;
        color_next    = color_reg;
        case (phase_reg)
            PH_COLOR: begin
                color_next = in_data;
                if (code_ext) phase_next = PH_LEN1;
            end
            PH_LEN1: begin
                run_len_next = len_shift;
                if (len_code_reg == LC_TWO) phase_next = PH_LEN2;
            end
            PH_LEN2: begin
                run_len_next = len_shift;
            end
            PH_LITERAL: begin
                lit_left_next = lit_left_reg - 1'b1;
                if (lit_left_reg == RUN_W'(1)) phase_next = PH_HEADER;
            end
            PH_STOPPED: begin
                phase_next = PH_STOPPED;
            end
            default: begin
                run_type_next = hdr_type;
                len_code_next = hdr_code;
                run_len_next  = hdr_len;
                if (hdr_type == RT_STOP) begin
                    phase_next = PH_STOPPED;
                end else if (hdr_type == RT_FILL) begin
                    phase_next = PH_COLOR;
                end else if (hdr_code == LC_ONE || hdr_code == LC_TWO) begin
                    phase_next = PH_LEN1;
                end else begin
                    phase_next = PH_HEADER;
                end
            end
        endcase
        if (fin) begin
            phase_next = PH_HEADER;
            if (fin_len != '0 && fin_type == RT_LITERAL) begin
                phase_next    = PH_LITERAL;
                lit_left_next = fin_len;
            end
        end
    end

    // command output
    always_comb begin
        emit       = 1'b0;
        emit_kind  = KIND_FRAME;
        emit_count = '0;
        emit_value = '0;
        if (phase_reg == PH_LITERAL) begin
            emit       = 1'b1;
            emit_kind  = KIND_LITERAL;
            emit_count = RUN_W'(1);
            emit_value = in_data;
        end else if (phase_reg == PH_HEADER && hdr_type == RT_STOP) begin
            emit      = 1'b1;
            emit_kind = KIND_STOP;
        end else if (fin && fin_len != '0 && fin_type != RT_LITERAL) begin
            emit       = 1'b1;
            emit_kind  = (fin_type == RT_FILL) ? KIND_FILL : KIND_SKIP;
            emit_count = fin_len;
            emit_value = (fin_type == RT_FILL) ? fin_color : '0;
        end
        // unused phase codes behave as header wait
        if (phase_reg != PH_HEADER && phase_reg != PH_COLOR && phase_reg != PH_LEN1 &&
            phase_reg != PH_LEN2 && phase_reg != PH_LITERAL && phase_reg != PH_STOPPED &&
            hdr_type == RT_STOP) begin
            emit      = 1'b1;
            emit_kind = KIND_STOP;
        end
        trunc = (phase_next == PH_COLOR) || (phase_next == PH_LEN1) ||
                (phase_next == PH_LEN2) || (phase_next == PH_LITERAL);

        push                = accept && (emit || in_last);
        push_cmd.kind       = emit ? emit_kind : KIND_FRAME;
        push_cmd.run_count  = emit ? emit_count : '0;
        push_cmd.value      = emit ? emit_value : '0;
        push_cmd.frame_end  = in_last;
        push_cmd.truncated  = in_last && trunc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            run_type_reg <= '0;
            len_code_reg <= '0;
            run_len_reg  <= '0;
            lit_left_reg <= '0;
            color_reg    <= '0;
        end else if (accept) begin
            if (in_last) begin
                // frame done: back to reset state
                phase_reg    <= PH_HEADER;
                run_type_reg <= '0;
                len_code_reg <= '0;
                run_len_reg  <= '0;
                lit_left_reg <= '0;
                color_reg    <= '0;
            end else begin
                phase_reg    <= phase_next;
                run_type_reg <= run_type_next;
                len_code_reg <= len_code_next;
                run_len_reg  <= run_len_next;
                lit_left_reg <= lit_left_next;
                color_reg    <= color_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_last) |=> (phase_reg == PH_HEADER && lit_left_reg == '0))
        else $error("front did not return to header wait after frame end");

    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_STOPPED && !in_last) |-> !push)
        else $error("word emitted after stop code");

    a_literal_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LITERAL) |-> (lit_left_reg != '0))
        else $error("literal phase with nothing left");
`endif

endmodule

### src/srd_queue.sv
// ----------------------------------------------------------------------------
// srd_queue
// Short command queue between the parser and the offset stage.
// ----------------------------------------------------------------------------
module srd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  srd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output srd_pkg::cmd_t head_cmd
);
    import srd_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("word pushed into full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### src/srd_back.sv
// ----------------------------------------------------------------------------
// srd_back
// Offset stage: assigns image offsets, saturates, and holds the output word.
// ----------------------------------------------------------------------------
module srd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            empty,
    input  srd_pkg::cmd_t                   head_cmd,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output srd_pkg::cmd_t                   out_cmd,
    output logic [srd_pkg::PIX_OFF_W-1:0]   out_offset,
    output logic                            out_overflow
);
    import srd_pkg::*;

    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic                   valid_reg;
    cmd_t                   cmd_reg;
    logic [PIX_OFF_W-1:0]   start_reg;
    logic                   ovf_reg;
    logic [SUM_W-1:0]       end_sum;
    logic                   ovf;

    assign pop     = !empty && (!valid_reg || out_ready);
    assign end_sum = SUM_W'(off_reg) + SUM_W'(head_cmd.run_count);
    assign ovf     = (end_sum > SUM_W'(OFF_MAX));

    always_comb begin
        off_next = off_reg;
        if (pop) begin
            if (head_cmd.frame_end) begin
                off_next = '0;
            end else if (ovf) begin
                off_next = OFF_MAX;
            end else begin
                off_next = end_sum[OFFSET_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            off_reg <= off_next;
            if (pop) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg   <= head_cmd;
            start_reg <= PIX_OFF_W'(off_reg);
            ovf_reg   <= ovf;
        end
    end

    assign out_valid    = valid_reg;
    assign out_cmd      = cmd_reg;
    assign out_offset   = start_reg;
    assign out_overflow = ovf_reg;

`ifndef NO_ASSERTIONS
    a_frame_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_cmd.frame_end) |=> (off_reg == '0))
        else $error("offset not cleared at frame end");

    a_ovf_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && ovf && !head_cmd.frame_end) |=> (off_reg == OFF_MAX))
        else $error("offset did not saturate");
`endif

endmodule

### src/sprite_rle_run_decoder.sv
// ----------------------------------------------------------------------------
// sprite_rle_run_decoder
// Decodes a sprite run-length byte stream into fill, skip and pixel words.
// ----------------------------------------------------------------------------
// Input stream: one compressed byte per word on s_tdata[7:0], s_tlast on the
// final byte of a frame. Output stream: one word per fill or skip run, one per
// literal byte, one for a stop code, and a frame-end word on s_tlast when the
// byte gave nothing else; m_tlast marks the word caused by the last byte.
// Each result passes through the command queue and then the output register.
// Throughput: one byte per cycle while the queue has room; the parser, the
// two-entry command queue and the offset stage each take one word per clock
// when not stalled, with the offset add and saturate compare as the longest path.
// While m_tready is low, the output word holds, the queue fills, and s_tready
// drops once both queue entries are taken; bytes that give no result keep
// flowing as long as the queue has room.
// Reset (aresetn low, synchronous) returns the parser to header wait, empties
// the queue, drops m_tvalid and clears the write offset to zero. Each frame
// end does the same for the parser state and the offset.
// ----------------------------------------------------------------------------
module sprite_rle_run_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // pixel_offset, run_count, value, truncated, overflow, pad
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import srd_pkg::*;

    logic                 push;
    cmd_t                 push_cmd;
    logic                 pop;
    logic                 full;
    logic                 empty;
    cmd_t                 head_cmd;
    cmd_t                 out_cmd;
    logic [PIX_OFF_W-1:0] out_offset;
    logic                 out_overflow;

    assign s_tready = !full;

    srd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .push     (push),
        .push_cmd (push_cmd)
    );

    srd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_cmd (head_cmd)
    );

    srd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty        (empty),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_cmd      (out_cmd),
        .out_offset   (out_offset),
        .out_overflow (out_overflow)
    );

    assign m_tdata = {2'b00, out_overflow, out_cmd.truncated, out_cmd.value,
                      out_cmd.run_count, out_offset};
    assign m_tuser = out_cmd.kind;
    assign m_tlast = out_cmd.frame_end;

endmodule

### bench/sprite_rle_run_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_rle_run_decoder_tb
// Stream-level check of the sprite run-length decoder. A short table of
// directed bytes covers the header types, length codes and frame-end cases.
// Random frames follow: well-formed command runs, noise, cut-off frames and
// long fill/skip chains that push the pixel offset into saturation. Every accepted
// byte goes through a behavioral decoder here, and every output word is
// compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module sprite_rle_run_decoder_tb;
    import srd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_BYTES  = 550;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        kind_t                kind;
        logic [PIX_OFF_W-1:0] offset;
        logic [RUN_W-1:0]     count;
        logic [BYTE_W-1:0]    value;
        logic                 frame_end;
        logic                 trunc;
        logic                 ovf;
    } run_word_t;

    // one input byte; fixed marks a row whose result is typed in the table
    typedef struct packed {
        logic [7:0] data;
        logic       tail;
        logic       fixed;
        run_word_t  want;
    } byte_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sprite_rle_run_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // behavioral decoder state
    // ------------------------------------------------------------------
    phase_t                 dec_phase;
    logic [1:0]             hdr_type;
    logic [1:0]             len_code;
    logic [RUN_W-1:0]       run_len;
    logic [RUN_W-1:0]       lit_left;
    logic [BYTE_W-1:0]      fill_val;
    logic [OFFSET_BITS-1:0] wr_off;

    run_word_t  run_q[$];      // predicted output words, oldest first
    byte_item_t offered_q[$];  // bytes put on the bus, not yet accepted
    byte_item_t frame_q[$];    // frame under construction

    int errors      = 0;
    int words_seen  = 0;
    int ovf_seen    = 0;
    int trunc_seen  = 0;
    int bytes_sent  = 0;
    int frames_made = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    function automatic void clear_decoder();
        dec_phase = PH_HEADER;
        hdr_type  = RT_LITERAL;
        len_code  = LC_NIBBLE;
        run_len   = '0;
        lit_left  = '0;
        fill_val  = '0;
        wr_off    = '0;
    endfunction

    // builds a word at the current offset and advances it, saturating
    function automatic run_word_t place_run(kind_t k, logic [RUN_W-1:0] cnt,
                                            logic [BYTE_W-1:0] val);
        run_word_t        w;
        logic [SUM_W-1:0] end_off;
        end_off     = SUM_W'(wr_off) + SUM_W'(cnt);
        w.kind      = k;
        w.offset    = wr_off[PIX_OFF_W-1:0];
        w.count     = cnt;
        w.value     = val;
        w.frame_end = 1'b0;
        w.trunc     = 1'b0;
        w.ovf       = (end_off > SUM_W'(OFF_MAX));
        wr_off      = w.ovf ? OFF_MAX : end_off[OFFSET_BITS-1:0];
        return w;
    endfunction

    // length known: literal runs switch to pixel mode, nonzero fill/skip emit one word
    function automatic bit close_command(output run_word_t w);
        dec_phase = PH_HEADER;
        if (run_len == '0)
            return 1'b0;
        if (hdr_type == RT_LITERAL) begin
            lit_left  = run_len;
            dec_phase = PH_LITERAL;
            return 1'b0;
        end
        if (hdr_type == RT_FILL)
            w = place_run(KIND_FILL, run_len, fill_val);
        else
            w = place_run(KIND_SKIP, run_len, 8'h00);
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic tail,
                                       output run_word_t w);
        bit got;
        bit cut;
        got = 1'b0;
        case (dec_phase)
            PH_COLOR: begin
                fill_val = b;
                if (len_code == LC_ONE || len_code == LC_TWO)
                    dec_phase = PH_LEN1;
                else
                    got = close_command(w);
            end
            PH_LEN1: begin
                run_len = {run_len[RUN_W-9:0], b};
                if (len_code == LC_TWO)
                    dec_phase = PH_LEN2;
                else
                    got = close_command(w);
            end
            PH_LEN2: begin
                run_len = {run_len[RUN_W-9:0], b};
                got = close_command(w);
            end
            PH_LITERAL: begin
                w   = place_run(KIND_LITERAL, RUN_W'(1), b);
                got = 1'b1;
                if (lit_left != '0)
                    lit_left = lit_left - 1'b1;
                if (lit_left == '0)
                    dec_phase = PH_HEADER;
            end
            PH_STOPPED: ;
            default: begin
                hdr_type = b[7:6];
                len_code = b[5:4];
                run_len  = (len_code == LC_NONE) ? '0 : RUN_W'(b[3:0]);
                if (hdr_type == RT_STOP) begin
                    w         = place_run(KIND_STOP, '0, 8'h00);
                    got       = 1'b1;
                    dec_phase = PH_STOPPED;
                end else if (hdr_type == RT_FILL) begin
                    dec_phase = PH_COLOR;
                end else if (len_code == LC_ONE || len_code == LC_TWO) begin
                    dec_phase = PH_LEN1;
                end else begin
                    got = close_command(w);
                end
            end
        endcase
        if (tail) begin
            cut = (dec_phase == PH_COLOR || dec_phase == PH_LEN1 ||
                   dec_phase == PH_LEN2 || dec_phase == PH_LITERAL);
            if (!got) begin
                w   = place_run(KIND_FRAME, '0, 8'h00);
                got = 1'b1;
            end
            w.frame_end = 1'b1;
            w.trunc     = cut;
            clear_decoder();
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // directed bytes
    // ------------------------------------------------------------------
    byte_item_t dir_rows [24] = '{
        // stop code, then an ignored byte closing the frame
        '{8'h40, 1'b0, 1'b1, '{KIND_STOP,  24'd0, 20'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{KIND_FRAME, 24'd0, 20'd0, 8'h00, 1'b1, 1'b0, 1'b0}},
        // fill of 5 with color AA
        '{8'h85, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b1, '{KIND_FILL,  24'd0, 20'd5, 8'hAA, 1'b0, 1'b0, 1'b0}},
        // skip with length code three: nothing
        '{8'hF7, 1'b0, 1'b0, '0},
        // two literal pixels, extreme values
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        // literal with one length byte
        '{8'h10, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h7E, 1'b0, 1'b0, '0},
        // longest skip
        '{8'hEF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        // zero-length literal
        '{8'h00, 1'b0, 1'b0, '0},
        // fill with two length bytes
        '{8'hA0, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, '0},
        // frame ends while a fill still waits for its length byte
        '{8'h9F, 1'b0, 1'b0, '0},
        '{8'h11, 1'b1, 1'b0, '0},
        // single-byte frame, empty command
        '{8'h00, 1'b1, 1'b1, '{KIND_FRAME, 24'd0, 20'd0, 8'h00, 1'b1, 1'b0, 1'b0}},
        // frame ends inside a literal run
        '{8'h03, 1'b0, 1'b0, '0},
        '{8'h12, 1'b1, 1'b1, '{KIND_LITERAL, 24'd0, 20'd1, 8'h12, 1'b1, 1'b1, 1'b0}}
    };

    // ------------------------------------------------------------------
    // random frame construction
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        byte_item_t it;
        it      = '0;
        it.data = b;
        frame_q.push_back(it);
    endtask

    task automatic add_command();
        int         pick;
        int         n;
        logic [1:0] lc;
        logic [3:0] nib;
        pick = $urandom_range(99);
        lc   = 2'($urandom_range(3));
        nib  = 4'($urandom_range(15));
        if (pick < 40) begin
            // literal runs stay short: long-form lengths use a zero high part
            case (lc)
                LC_NIBBLE: begin
                    push_byte({RT_LITERAL, lc, nib});
                    n = nib;
                end
                LC_ONE: begin
                    n = $urandom_range(20);
                    push_byte({RT_LITERAL, lc, 4'h0});
                    push_byte(8'(n));
                end
                LC_TWO: begin
                    n = $urandom_range(20);
                    push_byte({RT_LITERAL, lc, 4'h0});
                    push_byte(8'h00);
                    push_byte(8'(n));
                end
                default: begin
                    push_byte({RT_LITERAL, lc, nib});
                    n = 0;
                end
            endcase
            repeat (n) push_byte(8'($urandom_range(255)));
        end else if (pick < 97) begin
            push_byte({(pick < 70) ? RT_FILL : RT_SKIP, lc, nib});
            if (pick < 70)
                push_byte(8'($urandom_range(255)));
            if (lc == LC_ONE || lc == LC_TWO)
                push_byte(8'($urandom_range(255)));
            if (lc == LC_TWO)
                push_byte(8'($urandom_range(255)));
        end else begin
            push_byte({RT_STOP, 6'($urandom_range(63))});
        end
    endtask

    task automatic make_frame();
        int         shape;
        int         keep;
        byte_item_t it;
        frame_q.delete();
        shape = $urandom_range(99);
        if (shape < 4) begin
            // chain of maximal runs to drive the offset past its top
            repeat (17 + $urandom_range(3)) begin
                if ($urandom_range(1)) begin
                    push_byte({RT_SKIP, LC_TWO, 4'hF});
                end else begin
                    push_byte({RT_FILL, LC_TWO, 4'hF});
                    push_byte(8'($urandom_range(255)));
                end
                push_byte(8'hFF);
                push_byte(8'hFF);
            end
            repeat (1 + $urandom_range(2)) begin
                push_byte({RT_LITERAL, LC_NIBBLE, 4'h2});
                push_byte(8'($urandom_range(255)));
                push_byte(8'($urandom_range(255)));
            end
        end else if (shape < 12) begin
            repeat (1 + $urandom_range(11)) push_byte(8'($urandom_range(255)));
        end else begin
            repeat (1 + $urandom_range(7)) add_command();
        end
        // some frames are cut off at a random byte
        if ($urandom_range(99) < 12) begin
            keep = $urandom_range(frame_q.size(), 1);
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
        it      = frame_q.pop_back();
        it.tail = 1'b1;
        frame_q.push_back(it);
        frames_made++;
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_byte(input byte_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tlast  <= it.tail;
        offered_q.push_back(it);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // predict on every accepted word
    always @(posedge aclk) begin : in_mon
        byte_item_t it;
        run_word_t  w;
        bit         got;
        if (!aresetn) begin
            clear_decoder();
        end else if (s_tvalid && s_tready) begin
            it  = offered_q.pop_front();
            got = decode_byte(s_tdata, s_tlast, w);
            if (it.fixed)
                run_q.push_back(it.want);
            else if (got)
                run_q.push_back(w);
        end
    end

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done < holds_asked) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void cmp_field(string name, longint unsigned want,
                                      longint unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : out_mon
        run_word_t want;
        run_word_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.kind      = kind_t'(m_tuser);
            seen.offset    = m_tdata[23:0];
            seen.count     = m_tdata[43:24];
            seen.value     = m_tdata[51:44];
            seen.trunc     = m_tdata[52];
            seen.ovf       = m_tdata[53];
            seen.frame_end = m_tlast;
            words_seen++;
            if (seen.ovf)
                ovf_seen++;
            if (seen.trunc)
                trunc_seen++;
            if (run_q.size() == 0) begin
                $error("unexpected word: kind %0d offset %0h", seen.kind, seen.offset);
                errors++;
            end else begin
                want = run_q.pop_front();
                cmp_field("kind", want.kind, seen.kind);
                cmp_field("pixel_offset", want.offset, seen.offset);
                cmp_field("run_count", want.count, seen.count);
                cmp_field("value", want.value, seen.value);
                cmp_field("frame_end", want.frame_end, seen.frame_end);
                cmp_field("truncated", want.trunc, seen.trunc);
                cmp_field("overflow", want.ovf, seen.ovf);
            end
        end
    end

    // no handshake on either side for too long means the block is stuck
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d still expected",
                     STALL_LIMIT, run_q.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    int send_idle_by_phase [3] = '{8, 71, 0};
    int recv_idle_by_phase [3] = '{71, 8, 0};

    initial begin
        int phase_bytes;
        send_idle_pct = send_idle_by_phase[0];
        recv_idle_pct <= recv_idle_by_phase[0];
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i]);

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = send_idle_by_phase[p];
            recv_idle_pct <= recv_idle_by_phase[p];
            // long receiver stall while the sender keeps pushing
            if (p == 2)
                holds_asked <= holds_asked + 1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                make_frame();
                foreach (frame_q[i])
                    send_byte(frame_q[i]);
                phase_bytes += frame_q.size();
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (run_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d bytes in %0d random frames plus the directed table, %0d words checked",
                 bytes_sent, frames_made, words_seen);
        $display("     %0d saturated offsets, %0d truncated frame ends, %0d errors",
                 ovf_seen, trunc_seen, errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
src/srd_pkg.sv
src/srd_front.sv
src/srd_queue.sv
src/srd_back.sv
src/sprite_rle_run_decoder.sv
bench/sprite_rle_run_decoder_tb.sv
